/* hdl/des_pkg.sv */
// Package: DES permutation tables, S-boxes and helper functions.
package des_pkg;

	localparam int unsigned ROUNDS = 16;
	localparam int unsigned BLOCK_W = 64;
	localparam int unsigned SUBKEY_W = 48;

	typedef logic [63:0] block_t;
	typedef logic [47:0] subkey_t;
	typedef logic [27:0] half_t;

	localparam logic [3:0] REG_KEY = 4'h0;
	localparam logic [3:0] REG_MODE = 4'h1;

	typedef logic [6:0] tab64_t [64];
	typedef logic [6:0] tab56_t [56];
	typedef logic [6:0] tab48_t [48];
	typedef logic [6:0] tab32_t [32];

	localparam tab64_t IP_TAB = '{
		58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
		62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
		57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
		61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

	localparam tab64_t FP_TAB = '{
		40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
		38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
		36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
		34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

	localparam tab48_t E_TAB = '{
		32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
		16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};

	localparam tab32_t P_TAB = '{
		16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
		2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};

	localparam tab56_t PC1_TAB = '{
		57,49,41,33,25,17,9,1, 58,50,42,34,26,18,10,2,
		59,51,43,35,27,19,11,3, 60,52,44,36,
		63,55,47,39,31,23,15,7, 62,54,46,38,30,22,14,6,
		61,53,45,37,29,21,13,5, 28,20,12,4};

	localparam tab48_t PC2_TAB = '{
		14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
		41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};

	localparam logic [1:0] SHIFT_TAB [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

	typedef logic [3:0] sbox_t [8][64];
	localparam sbox_t SBOX = '{
		'{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
		  0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
		  4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
		  15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
		'{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
		  3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
		  0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
		  13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
		'{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
		  13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
		  13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
		  1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
		'{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
		  13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
		  10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
		  3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
		'{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
		  14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
		  4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
		  11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
		'{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
		  10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
		  9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
		  4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
		'{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
		  13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
		  1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
		  6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
		'{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
		  1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
		  7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
		  2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

	// table entries count from the MSB, starting at 1
	function automatic block_t ip_perm(input block_t x);
		block_t r;
		for (int k = 0; k < 64; k++) r[63-k] = x[64-IP_TAB[k]];
		return r;
	endfunction

	function automatic block_t fp_perm(input block_t x);
		block_t r;
		for (int k = 0; k < 64; k++) r[63-k] = x[64-FP_TAB[k]];
		return r;
	endfunction

	function automatic logic [55:0] pc1_perm(input block_t x);
		logic [55:0] r;
		for (int k = 0; k < 56; k++) r[55-k] = x[64-PC1_TAB[k]];
		return r;
	endfunction

	function automatic subkey_t pc2_perm(input logic [55:0] x);
		subkey_t r;
		for (int k = 0; k < 48; k++) r[47-k] = x[56-PC2_TAB[k]];
		return r;
	endfunction

	function automatic half_t rot28(input half_t x, input logic [1:0] s);
		half_t r;
		r = x;
		if (s == 2'd1) r = {x[26:0], x[27]};
		else if (s == 2'd2) r = {x[25:0], x[27:26]};
		return r;
	endfunction

	function automatic logic [31:0] feistel(input logic [31:0] r, input subkey_t k);
		subkey_t x;
		logic [31:0] s;
		logic [31:0] p;
		logic [5:0] six;
		for (int j = 0; j < 48; j++) x[47-j] = r[32-E_TAB[j]];
		x = x ^ k;
		for (int i = 0; i < 8; i++) begin
			six = x[47-6*i -: 6];
			s[31-4*i -: 4] = SBOX[i][{six[5], six[0], six[4:1]}];
		end
		for (int j = 0; j < 32; j++) p[31-j] = s[32-P_TAB[j]];
		return p;
	endfunction

endpackage

/* hdl/des_block_cipher_core.sv */
// Top level: fully pipelined DES ECB cipher with APB key and mode registers.
//
//  channel | direction | handshake                 | payload
//  s_axis  | in        | s_axis_tvalid/tready      | s_axis_tdata[63:0] block_in
//  m_axis  | out       | m_axis_tvalid/tready      | m_axis_tdata[63:0] block_out
//  apb     | in        | psel/penable/pwrite/pready| reg 0 key (addr 0), reg 1 mode (addr 8)
//
// One beat per cycle while m_axis does not stall; the pipeline has one stage for IP and
// one per Feistel round, with IP inverse folded into the output stage of the last round.
// Subkeys are computed from the key register; the user must change it only while idle (not enforced).
// A stall at m_axis freezes every stage at once (global enable), so nothing is
// lost or repeated; tready is high whenever the output stage can take data.
// Reset clears the valid bits and the registers (key 0, encrypt).
module des_block_cipher_core #(
	parameter int unsigned ROUNDS = des_pkg::ROUNDS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [63:0] block_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [63:0] block_out
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	logic [63:0] key_q;
	logic        mode_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q  <= '0;
			mode_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			if (paddr == {des_pkg::REG_KEY[0], 3'b000}) key_q <= pwdata;
			else if (paddr == {des_pkg::REG_MODE[0], 3'b000}) mode_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == {des_pkg::REG_KEY[0], 3'b000}) prdata = key_q;
		else if (paddr == {des_pkg::REG_MODE[0], 3'b000}) prdata = {63'd0, mode_q};
	end

	// key schedule: the user must keep the key static while items are in flight (not enforced)
	des_pkg::subkey_t sub [ROUNDS];
	des_pkg::half_t   c_w [ROUNDS+1];
	des_pkg::half_t   d_w [ROUNDS+1];
	logic [55:0]      cd0;

	assign cd0    = des_pkg::pc1_perm(key_q);
	assign c_w[0] = cd0[55:28];
	assign d_w[0] = cd0[27:0];

	for (genvar i = 0; i < ROUNDS; i++) begin : g_ks
		assign c_w[i+1] = des_pkg::rot28(c_w[i], des_pkg::SHIFT_TAB[i % 16]);
		assign d_w[i+1] = des_pkg::rot28(d_w[i], des_pkg::SHIFT_TAB[i % 16]);
		assign sub[i]   = des_pkg::pc2_perm({c_w[i+1], d_w[i+1]});
	end

	// pipeline: stage 0 holds IP output, stage i+1 holds round i output
	logic        adv;
	logic        vld_s [ROUNDS+1];
	logic [31:0] l_s   [ROUNDS+1];
	logic [31:0] r_s   [ROUNDS+1];
	des_pkg::block_t ip_w;

	assign adv           = m_axis_tready || !m_axis_tvalid;
	assign s_axis_tready = adv;
	assign ip_w          = des_pkg::ip_perm(s_axis_tdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			l_s[0] <= ip_w[63:32];
			r_s[0] <= ip_w[31:0];
		end
	end

	for (genvar i = 0; i < ROUNDS; i++) begin : g_rnd
		des_pkg::subkey_t k_w;
		assign k_w = mode_q ? sub[ROUNDS-1-i] : sub[i];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (adv) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				l_s[i+1] <= r_s[i];
				r_s[i+1] <= l_s[i] ^ des_pkg::feistel(r_s[i], k_w);
			end
		end
	end

	assign m_axis_tvalid = vld_s[ROUNDS];
	assign m_axis_tdata  = des_pkg::fp_perm({r_s[ROUNDS], l_s[ROUNDS]});

endmodule

/* tb/tb_des_block_cipher_core.sv */
// Testbench for the DES ECB core: predicts each block and checks every output beat.
module tb_des_block_cipher_core;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;

	des_block_cipher_core u_dut (.*);

	always #4 clk = ~clk;

	// Register addresses: 64-bit key register forces 8-byte spacing.
	localparam logic [3:0] ADDR_KEY  = {des_pkg::REG_KEY[0], 3'b000};
	localparam logic [3:0] ADDR_MODE = {des_pkg::REG_MODE[0], 3'b000};
	localparam int         WATCHDOG_LIMIT = 4000;
	localparam int         PIPE_DRAIN = des_pkg::ROUNDS + 8;

	// Predictor state: own copy of the key and the direction bit
	des_pkg::block_t  model_key;
	logic             model_decrypt;

	// Pending input blocks for the driver and expected cipher outputs for the monitor
	des_pkg::block_t  pending_blocks[$];
	des_pkg::block_t  expected_blocks[$];
	int      mismatch_count = 0;
	int      idle_cycles = 0;
	bit      driver_busy;

	// Bit k counts from the MSB of a w-bit value, starting at 1, like the published tables
	function automatic logic bit_select(input logic [63:0] x, input int w, input int src);
		return x[w - src];
	endfunction

	function automatic logic [27:0] rotate_half(input logic [27:0] x, input int s);
		return ((x << s) | (x >> (28 - s))) & 28'hFFFFFFF;
	endfunction

	function automatic logic [31:0] round_function(input logic [31:0] r,
			input logic [47:0] k);
		logic [47:0] x;
		logic [31:0] s;
		logic [31:0] p;
		logic [5:0]  six;
		x = '0;
		for (int j = 0; j < 48; j++)
			x = {x[46:0], bit_select({32'd0, r}, 32, int'(des_pkg::E_TAB[j]))};
		x = x ^ k;
		s = '0;
		for (int i = 0; i < 8; i++) begin
			six = x[47 - 6*i -: 6];
			s = {s[27:0], des_pkg::SBOX[i][{six[5], six[0], six[4:1]}]};
		end
		p = '0;
		for (int j = 0; j < 32; j++)
			p = {p[30:0], bit_select({32'd0, s}, 32, int'(des_pkg::P_TAB[j]))};
		return p;
	endfunction

	function automatic des_pkg::block_t des_cipher(input des_pkg::block_t blk_in,
			input des_pkg::block_t key, input logic decrypt);
		logic [47:0] subkeys [16];
		logic [55:0] cd;
		logic [27:0] c;
		logic [27:0] d;
		logic [47:0] sk;
		des_pkg::block_t blk;
		logic [31:0] l;
		logic [31:0] r;
		logic [31:0] t;
		des_pkg::block_t res;
		cd = '0;
		for (int k = 0; k < 56; k++)
			cd = {cd[54:0], bit_select(key, 64, int'(des_pkg::PC1_TAB[k]))};
		c = cd[55:28];
		d = cd[27:0];
		for (int i = 0; i < 16; i++) begin
			c = rotate_half(c, int'(des_pkg::SHIFT_TAB[i]));
			d = rotate_half(d, int'(des_pkg::SHIFT_TAB[i]));
			sk = '0;
			for (int k = 0; k < 48; k++)
				sk = {sk[46:0], bit_select({8'd0, c, d}, 56, int'(des_pkg::PC2_TAB[k]))};
			subkeys[i] = sk;
		end
		blk = '0;
		for (int k = 0; k < 64; k++)
			blk = {blk[62:0], bit_select(blk_in, 64, int'(des_pkg::IP_TAB[k]))};
		l = blk[63:32];
		r = blk[31:0];
		for (int i = 0; i < 16; i++) begin
			t = l ^ round_function(r, subkeys[decrypt ? 15 - i : i]);
			l = r;
			r = t;
		end
		res = '0;
		for (int k = 0; k < 64; k++)
			res = {res[62:0], bit_select({r, l}, 64, int'(des_pkg::FP_TAB[k]))};
		return res;
	endfunction

	function automatic des_pkg::block_t random_block();
		return {$urandom, $urandom};
	endfunction

	// Sampled handshake flags from the rising edge
	logic s_axis_tready_q = 1'b0;
	logic m_acc_q = 1'b0;
	always @(posedge clk) begin
		s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
		m_acc_q <= m_axis_tvalid && m_axis_tready;
		if (s_axis_tvalid && s_axis_tready)
			expected_blocks.push_back(des_cipher(s_axis_tdata, model_key, model_decrypt));
	end

	// Driver: one beat from the queue at a time, random gap before each
	int send_gap = 0;
	always @(negedge clk) begin
		int gap;
		if (s_axis_tvalid && s_axis_tready_q) begin
			// beat taken at the last rising edge
			void'(pending_blocks.pop_front());
			gap = $urandom_range(0, 13) * ($urandom_range(0, 3) != 0);
			if (gap == 0 && pending_blocks.size() != 0) begin
				// next beat follows with no gap
				s_axis_tdata <= pending_blocks[0];
			end else begin
				s_axis_tvalid <= 1'b0;
				send_gap <= (gap == 0) ? 0 : gap - 1;
			end
		end else if (!s_axis_tvalid && pending_blocks.size() != 0 && driver_busy) begin
			if (send_gap == 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= pending_blocks[0];
			end else begin
				send_gap <= send_gap - 1;
			end
		end
	end

	// Monitor: compare each output beat with the oldest expectation
	always @(posedge clk) begin
		des_pkg::block_t want;
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_blocks.size() == 0) begin
				mismatch_count <= mismatch_count + 1;
				if (mismatch_count < 10)
					$display("unexpected output beat %h", m_axis_tdata);
			end else begin
				want = expected_blocks.pop_front();
				if (m_axis_tdata !== want) begin
					mismatch_count <= mismatch_count + 1;
					if (mismatch_count < 10)
						$display("block_out mismatch: expected %h actual %h",
							want, m_axis_tdata);
				end
			end
		end
	end

	// Receiver stall: random wait per beat, with stretches of none
	int recv_gap = 0;
	bit recv_nostall = 1'b0;
	always @(negedge clk) begin
		if (m_acc_q) begin
			recv_gap = recv_nostall ? 0 : $urandom_range(0, 13);
			if ($urandom_range(0, 63) == 0) recv_nostall = !recv_nostall;
		end
		if (recv_gap == 0) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= 1'b0;
			recv_gap = recv_gap - 1;
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// APB write: setup then access; register updates at the access edge
	task automatic reg_write(input logic [3:0] addr, input logic [63:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_KEY) model_key = data;
		else if (addr == ADDR_MODE) model_decrypt = data[0];
	endtask

	// Wait until the stream drains, then let the pipeline settle
	task automatic wait_drained();
		while (pending_blocks.size() != 0 || s_axis_tvalid || expected_blocks.size() != 0)
			@(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
	endtask

	task automatic run_blocks(input int count);
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 7))
				0: pending_blocks.push_back(64'd0);
				1: pending_blocks.push_back('1);
				2: pending_blocks.push_back(64'd1 << $urandom_range(0, 63));
				default: pending_blocks.push_back(random_block());
			endcase
		end
	endtask

	initial begin
		des_pkg::block_t keys [$];
		driver_busy = 1'b0;
		model_key = '0;
		model_decrypt = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		driver_busy = 1'b1;

		// Directed: reset key 0, then the published test vector, extremes
		pending_blocks.push_back(64'd0);
		pending_blocks.push_back('1);
		wait_drained();
		reg_write(ADDR_KEY, 64'h133457799BBCDFF1);
		pending_blocks.push_back(64'h0123456789ABCDEF);
		pending_blocks.push_back(64'd0);
		pending_blocks.push_back('1);
		pending_blocks.push_back(64'h8000000000000001);
		wait_drained();
		// parity bits flipped must not change the result
		reg_write(ADDR_KEY, 64'h133457799BBCDFF1 ^ 64'h0101010101010101);
		pending_blocks.push_back(64'h0123456789ABCDEF);
		wait_drained();
		reg_write(ADDR_MODE, 64'd1);
		pending_blocks.push_back(64'h85E813540F0AB405);
		pending_blocks.push_back(64'hAAAAAAAAAAAAAAAA);
		wait_drained();
		// extra mode bits: only bit 0 is kept
		reg_write(ADDR_MODE, 64'hFFFFFFFFFFFFFFFE);
		pending_blocks.push_back(64'h5555555555555555);
		wait_drained();
		// weak keys and all-ones key, both directions
		keys = '{64'h0101010101010101, 64'hFEFEFEFEFEFEFEFE, 64'hE0E0E0E0F1F1F1F1,
			'1, 64'd0};
		foreach (keys[i]) begin
			reg_write(ADDR_KEY, keys[i]);
			reg_write(ADDR_MODE, 64'(i % 2));
			pending_blocks.push_back(random_block());
			pending_blocks.push_back(random_block());
			wait_drained();
		end

		// Random phases with random keys and directions
		for (int ph = 0; ph < 19; ph++) begin
			reg_write(ADDR_KEY, random_block());
			reg_write(ADDR_MODE, {$urandom, $urandom});
			run_blocks(50);
			wait_drained();
		end

		wait_drained();
		if (mismatch_count == 0 && expected_blocks.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

/* filelist.f */
hdl/des_pkg.sv
hdl/des_block_cipher_core.sv
tb/tb_des_block_cipher_core.sv
